FILE: hw/rtl/playfair_digraph_cipher_top_macros.svh
// Assertion macros shared by the Playfair cipher RTL.
// Used by files that hold concurrent assertions; needs a clk and rst_n in scope.
`ifndef PLAYFAIR_DIGRAPH_CIPHER_TOP_MACROS_SVH
`define PLAYFAIR_DIGRAPH_CIPHER_TOP_MACROS_SVH

// Consequent must hold in the same cycle as the antecedent.
`define PFC_CHECK_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define PFC_CHECK_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: hw/rtl/pfc_pkg.sv
// Package for the Playfair digraph cipher: payload structs, command codes,
// letter constants and small helper functions. No dependencies.
`default_nettype none

package pfc_pkg;

  // Command codes.
  localparam logic [1:0] CMD_CLEAR    = 2'd0;
  localparam logic [1:0] CMD_KEY      = 2'd1;
  localparam logic [1:0] CMD_FINALIZE = 2'd2;
  localparam logic [1:0] CMD_ENCRYPT  = 2'd3;

  // Letter codes and square geometry.
  localparam logic [4:0] LETTER_I = 5'd8;
  localparam logic [4:0] LETTER_J = 5'd9;
  localparam logic [4:0] LETTER_X = 5'd23;
  localparam logic [4:0] LETTER_Z = 5'd25;
  localparam logic [4:0] LETTERS  = 5'd26;
  localparam logic [4:0] CELLS    = 5'd25;
  localparam logic [2:0] SIDE_MAX = 3'd4;
  localparam int unsigned NUM_LETTERS = 26;
  localparam int unsigned NUM_CELLS   = 25;

  // Seen set after reset or clear: J always counts as used.
  localparam logic [25:0] SEEN_INIT = 26'(1) << LETTER_J;

  typedef struct packed {
    logic [1:0] command;
    logic [4:0] letter_a;
    logic [4:0] letter_b;
    logic       has_second;
  } in_t;

  typedef struct packed {
    logic [4:0] cipher_first;
    logic [4:0] cipher_second;
    logic       not_ready;
  } out_t;

  // Position of a letter in the square, kept as row and column.
  typedef struct packed {
    logic [2:0] row;
    logic [2:0] col;
  } pos_t;

  // Append command broadcast to every lane's stores.
  typedef struct packed {
    logic       we;
    logic [4:0] cell_addr;
    logic [4:0] letter;
    pos_t       pos;
  } pfc_wr_t;

  // Saturate a plaintext letter to Z and fold J onto I.
  function automatic logic [4:0] plain_letter(input logic [4:0] v);
    logic [4:0] c;
    c = (v > LETTER_Z) ? LETTER_Z : v;
    return (c == LETTER_J) ? LETTER_I : c;
  endfunction

  // Row-major cell index: row * 5 + col.
  function automatic logic [4:0] cell_index(input logic [2:0] row, input logic [2:0] col);
    return {row[2:0], 2'b00} + 5'(row) + 5'(col);
  endfunction

  // Step one place along a row or column of the square, wrapping.
  function automatic logic [2:0] wrap_inc(input logic [2:0] v);
    return (v == SIDE_MAX) ? 3'd0 : v + 3'd1;
  endfunction

endpackage

`default_nettype wire

FILE: hw/rtl/pfc_lane.sv
// One lookup lane: a copy of the letter-position store and the cell store,
// each with a registered read port. Depends on pfc_pkg.
`default_nettype none

module pfc_lane (
  input  wire logic            clk,
  input  wire pfc_pkg::pfc_wr_t wr,
  input  wire logic            pos_rd_en,
  input  wire logic [4:0]      pos_rd_addr,
  output pfc_pkg::pos_t        pos_q,
  input  wire logic            cell_rd_en,
  input  wire logic [4:0]      cell_rd_addr,
  output logic [4:0]           cell_q
);

  pfc_pkg::pos_t pos_mem  [pfc_pkg::NUM_LETTERS];
  logic [4:0]    cell_mem [pfc_pkg::NUM_CELLS];
  pfc_pkg::pos_t pos_q_r;
  logic [4:0]    cell_q_r;

  // Both stores take the same append: letter into its cell, cell into the letter's slot.
  always_ff @(posedge clk) begin
    if (wr.we) begin
      cell_mem[wr.cell_addr] <= wr.letter;
      pos_mem[wr.letter]     <= wr.pos;
    end
  end

  // Registered reads; data holds until the next enabled read.
  always_ff @(posedge clk) begin
    if (pos_rd_en) begin
      pos_q_r <= pos_mem[pos_rd_addr];
    end
    if (cell_rd_en) begin
      cell_q_r <= cell_mem[cell_rd_addr];
    end
  end

  assign pos_q  = pos_q_r;
  assign cell_q = cell_q_r;

endmodule

`default_nettype wire

FILE: hw/rtl/pfc_merge.sv
// Merge stage: combines the two lanes' letter positions and picks the
// ciphertext cells by the row, column and rectangle rules. Depends on pfc_pkg.
`default_nettype none

module pfc_merge (
  input  wire pfc_pkg::pos_t pos_a,
  input  wire pfc_pkg::pos_t pos_b,
  output logic [4:0]         cell_a,
  output logic [4:0]         cell_b
);

  logic [2:0] row_a;
  logic [2:0] col_a;
  logic [2:0] row_b;
  logic [2:0] col_b;

  // Same row shifts right, same column shifts down, otherwise swap corners.
  always_comb begin
    if (pos_a.row == pos_b.row) begin
      row_a = pos_a.row;
      col_a = pfc_pkg::wrap_inc(pos_a.col);
      row_b = pos_b.row;
      col_b = pfc_pkg::wrap_inc(pos_b.col);
    end else if (pos_a.col == pos_b.col) begin
      row_a = pfc_pkg::wrap_inc(pos_a.row);
      col_a = pos_a.col;
      row_b = pfc_pkg::wrap_inc(pos_b.row);
      col_b = pos_b.col;
    end else begin
      row_a = pos_a.row;
      col_a = pos_b.col;
      row_b = pos_b.row;
      col_b = pos_a.col;
    end
  end

  assign cell_a = pfc_pkg::cell_index(row_a, col_a);
  assign cell_b = pfc_pkg::cell_index(row_b, col_b);

endmodule

`default_nettype wire

FILE: hw/rtl/playfair_digraph_cipher_top.sv
// Top level of the Playfair digraph cipher: command sequencer, square fill
// logic, two lookup lanes and the merge stage. Depends on pfc_pkg, pfc_lane,
// pfc_merge and the assertion macro header.
//
//  Channel | Ports                        | Moves
//  --------+------------------------------+-------------------------------------
//  input   | in_valid, in_ready, in_data  | one command transaction (pfc_pkg::in_t)
//  output  | out_valid, out_ready, out_data | one cipher pair (pfc_pkg::out_t)
//
// Clear and key letter are handled in the accepting cycle. In an encrypt the lanes first read the
// letter positions, then the merged cell addresses are read into the output register.
// Finalize: after the accepting cycle, it sweeps one letter a cycle through all 26 letters.
// Reset is synchronous, active low, and clears the control state only.
// A result waiting on out_ready does not block the next input transaction;
// a second encrypt holds in its cell-read step until the output register frees.
`default_nettype none

`include "playfair_digraph_cipher_top_macros.svh"

module playfair_digraph_cipher_top (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          in_valid,
  output logic               in_ready,
  input  wire pfc_pkg::in_t  in_data,
  output logic               out_valid,
  input  wire logic          out_ready,
  output pfc_pkg::out_t      out_data
);

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_CELL = 2'd1;
  localparam logic [1:0] ST_FIN  = 2'd2;

  logic [1:0]  state_r, state_nxt;
  logic        ready_r, ready_nxt;
  logic [25:0] seen_r, seen_nxt;
  logic [4:0]  fill_cnt_r, fill_cnt_nxt;
  logic [2:0]  fill_row_r, fill_row_nxt;
  logic [2:0]  fill_col_r, fill_col_nxt;
  logic [4:0]  fin_ltr_r, fin_ltr_nxt;
  logic        nr_r, nr_nxt;
  logic        out_valid_r, out_valid_nxt;
  logic        out_nr_r, out_nr_nxt;

  logic             in_fire;
  logic             slot_free;
  logic [4:0]       let_a;
  logic [4:0]       let_b_raw;
  logic [4:0]       let_b;
  logic             key_ok;
  logic             fin_ok;
  logic             app_en;
  logic [4:0]       app_ltr;
  pfc_pkg::pfc_wr_t wr;
  logic             pos_rd_en;
  logic             cell_rd_en;
  pfc_pkg::pos_t    pos_a;
  pfc_pkg::pos_t    pos_b;
  logic [4:0]       cell_addr_a;
  logic [4:0]       cell_addr_b;
  logic [4:0]       cell_q_a;
  logic [4:0]       cell_q_b;

  // Handshake.
  assign in_ready  = (state_r == ST_IDLE);
  assign in_fire   = in_valid && in_ready;
  assign slot_free = !out_valid_r || out_ready;

  // Plaintext letters: fold J, pad a missing or repeated second letter with X.
  assign let_a     = pfc_pkg::plain_letter(in_data.letter_a);
  assign let_b_raw = in_data.has_second ? pfc_pkg::plain_letter(in_data.letter_b)
                                        : pfc_pkg::LETTER_X;
  assign let_b     = (let_b_raw == let_a) ? pfc_pkg::LETTER_X : let_b_raw;

  // Append port: a key letter from the input or the finalize sweep letter.
  assign key_ok  = in_fire && (in_data.command == pfc_pkg::CMD_KEY) &&
                   (in_data.letter_a < pfc_pkg::LETTERS) && !ready_r &&
                   !seen_r[in_data.letter_a] && (fill_cnt_r < pfc_pkg::CELLS);
  assign fin_ok  = (state_r == ST_FIN) && !seen_r[fin_ltr_r] &&
                   (fill_cnt_r < pfc_pkg::CELLS);
  assign app_en  = key_ok || fin_ok;
  assign app_ltr = (state_r == ST_FIN) ? fin_ltr_r : in_data.letter_a;

  always_comb begin
    wr.we        = app_en;
    wr.cell_addr = fill_cnt_r;
    wr.letter    = app_ltr;
    wr.pos.row   = fill_row_r;
    wr.pos.col   = fill_col_r;
  end

  assign pos_rd_en  = in_fire && (in_data.command == pfc_pkg::CMD_ENCRYPT);
  assign cell_rd_en = (state_r == ST_CELL) && slot_free;

  // Lookup lanes, one per letter of the pair.
  pfc_lane u_lane_a (
    .clk          (clk),
    .wr           (wr),
    .pos_rd_en    (pos_rd_en),
    .pos_rd_addr  (let_a),
    .pos_q        (pos_a),
    .cell_rd_en   (cell_rd_en),
    .cell_rd_addr (cell_addr_a),
    .cell_q       (cell_q_a)
  );

  pfc_lane u_lane_b (
    .clk          (clk),
    .wr           (wr),
    .pos_rd_en    (pos_rd_en),
    .pos_rd_addr  (let_b),
    .pos_q        (pos_b),
    .cell_rd_en   (cell_rd_en),
    .cell_rd_addr (cell_addr_b),
    .cell_q       (cell_q_b)
  );

  pfc_merge u_merge (
    .pos_a  (pos_a),
    .pos_b  (pos_b),
    .cell_a (cell_addr_a),
    .cell_b (cell_addr_b)
  );

  // Sequencer and square bookkeeping.
  always_comb begin
    state_nxt     = state_r;
    ready_nxt     = ready_r;
    seen_nxt      = seen_r;
    fill_cnt_nxt  = fill_cnt_r;
    fill_row_nxt  = fill_row_r;
    fill_col_nxt  = fill_col_r;
    fin_ltr_nxt   = fin_ltr_r;
    nr_nxt        = nr_r;
    out_valid_nxt = out_valid_r;
    out_nr_nxt    = out_nr_r;

    if (out_valid_r && out_ready) begin
      out_valid_nxt = 1'b0;
    end

    // Advance the fill pointer on every append.
    if (app_en) begin
      seen_nxt[app_ltr] = 1'b1;
      fill_cnt_nxt      = fill_cnt_r + 5'd1;
      if (fill_col_r == pfc_pkg::SIDE_MAX) begin
        fill_col_nxt = 3'd0;
        fill_row_nxt = fill_row_r + 3'd1;
      end else begin
        fill_col_nxt = fill_col_r + 3'd1;
      end
    end

    unique case (state_r)
      ST_IDLE: begin
        if (in_fire) begin
          unique case (in_data.command)
            pfc_pkg::CMD_CLEAR: begin
              seen_nxt     = pfc_pkg::SEEN_INIT;
              fill_cnt_nxt = 5'd0;
              fill_row_nxt = 3'd0;
              fill_col_nxt = 3'd0;
              ready_nxt    = 1'b0;
            end
            pfc_pkg::CMD_KEY: begin
            end
            pfc_pkg::CMD_FINALIZE: begin
              fin_ltr_nxt = 5'd0;
              state_nxt   = ST_FIN;
            end
            pfc_pkg::CMD_ENCRYPT: begin
              nr_nxt    = !ready_r;
              state_nxt = ST_CELL;
            end
            default: begin
            end
          endcase
        end
      end
      ST_CELL: begin
        if (slot_free) begin
          out_valid_nxt = 1'b1;
          out_nr_nxt    = nr_r;
          state_nxt     = ST_IDLE;
        end
      end
      ST_FIN: begin
        fin_ltr_nxt = fin_ltr_r + 5'd1;
        if (fin_ltr_r == pfc_pkg::LETTER_Z) begin
          ready_nxt = 1'b1;
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      ready_r     <= 1'b0;
      seen_r      <= pfc_pkg::SEEN_INIT;
      fill_cnt_r  <= 5'd0;
      fill_row_r  <= 3'd0;
      fill_col_r  <= 3'd0;
      fin_ltr_r   <= 5'd0;
      nr_r        <= 1'b0;
      out_valid_r <= 1'b0;
      out_nr_r    <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      ready_r     <= ready_nxt;
      seen_r      <= seen_nxt;
      fill_cnt_r  <= fill_cnt_nxt;
      fill_row_r  <= fill_row_nxt;
      fill_col_r  <= fill_col_nxt;
      fin_ltr_r   <= fin_ltr_nxt;
      nr_r        <= nr_nxt;
      out_valid_r <= out_valid_nxt;
      out_nr_r    <= out_nr_nxt;
    end
  end

  // Result: the lanes' cell registers form the output payload.
  assign out_valid              = out_valid_r;
  assign out_data.cipher_first  = out_nr_r ? 5'd0 : cell_q_a;
  assign out_data.cipher_second = out_nr_r ? 5'd0 : cell_q_b;
  assign out_data.not_ready     = out_nr_r;

  // The fill count never runs past the square.
  `PFC_CHECK_NOW(fill_in_range, 1'b1, fill_cnt_r <= pfc_pkg::CELLS, "fill count past 25")
  // The row and column pointer tracks the fill count.
  `PFC_CHECK_NOW(fill_pos_match, 1'b1,
    pfc_pkg::cell_index(fill_row_r, fill_col_r) == fill_cnt_r, "fill row/col out of step")
  // A finished square is completely filled.
  `PFC_CHECK_NOW(ready_means_full, ready_r, fill_cnt_r == pfc_pkg::CELLS,
    "square ready but not full")
  // A real cipher pair is only produced from a ready square.
  `PFC_CHECK_NOW(cipher_needs_square, (state_r == ST_CELL) && !nr_r, ready_r,
    "cipher lookup without a ready square")
  // Finalize always ends with the square ready.
  `PFC_CHECK_NEXT(finalize_sets_ready, (state_r == ST_FIN) &&
    (fin_ltr_r == pfc_pkg::LETTER_Z), ready_r && (state_r == ST_IDLE),
    "finalize did not complete")

endmodule

`default_nettype wire
